// ===== hdl/aws_pkg.sv =====
// Shared types, codes, constants and the target table of the ACK window shaper.
package aws_pkg;

	// field widths
	localparam int STATE_W   = 3;
	localparam int SCORE_W   = 7;
	localparam int LOSS_W    = 16;
	localparam int WIN_W     = 16;
	localparam int VERDICT_W = 2;
	localparam int DUP_W     = 3;
	localparam int SCALE_W   = 7;
	localparam int CNT_W     = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int STEP_W    = 7;
	localparam int PROD_W    = WIN_W + SCALE_W;

	// connection state codes
	localparam logic [STATE_W-1:0] ST_NORMAL     = 3'd0;
	localparam logic [STATE_W-1:0] ST_RAND_LOSS  = 3'd1;
	localparam logic [STATE_W-1:0] ST_DELAY_FLAT = 3'd2;
	localparam logic [STATE_W-1:0] ST_DELAY_RISE = 3'd3;
	localparam logic [STATE_W-1:0] ST_BURST_LOSS = 3'd4;
	localparam logic [STATE_W-1:0] ST_RECOVER    = 3'd5;

	// verdict codes
	localparam logic [VERDICT_W-1:0] VERDICT_SAME = 2'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_MOD  = 2'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_SUPP = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WINDOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UP_STEP    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOWN_STEP  = 2'd2;

	// reset values
	localparam logic [WIN_W-1:0]   MIN_WINDOW_RST = 16'd4096;
	localparam logic [STEP_W-1:0]  UP_STEP_RST    = 7'd8;
	localparam logic [STEP_W-1:0]  DOWN_STEP_RST  = 7'd3;
	localparam logic [SCALE_W-1:0] SCALE_FULL     = 7'd100;

	// suppression rule
	localparam logic [SCORE_W-1:0] SUPP_SCORE = 7'd99;
	localparam logic [CNT_W-1:0]   SUPP_MAX   = 2'd2;

	// loss cap rule
	localparam logic [SCORE_W-1:0] CAP_SCORE = 7'd70;
	localparam logic [SCALE_W-1:0] CAP_SCALE = 7'd55;

	// duplicate ACK thresholds
	localparam logic [DUP_W-1:0] DUP_LOSSY = 3'd5;
	localparam logic [DUP_W-1:0] DUP_BASE  = 3'd3;

	// divide by 100: floor(p * DIV_MULT / 2^DIV_SHIFT), exact for p < 2^23
	localparam int              DIV_SHIFT = 30;
	localparam int              RECIP_W   = 24;
	localparam logic [RECIP_W-1:0] DIV_MULT = 24'd10737419;
	localparam int              FULL_W    = PROD_W + RECIP_W;

	// decision made for one ACK in the input stage
	typedef struct packed {
		logic               suppress;
		logic [SCALE_W-1:0] scale;
		logic [CNT_W-1:0]   cnt;
		logic [DUP_W-1:0]   dup;
	} decision_t;

	// per-state target scale, with the loss cap
	function automatic logic [SCALE_W-1:0] pick_target(
		input logic [STATE_W-1:0] st,
		input logic [SCORE_W-1:0] score,
		input logic [LOSS_W-1:0]  loss
	);
		logic [SCALE_W-1:0] t;
		unique case (st)
			ST_NORMAL:
				t = (loss > 16'd5) ? 7'd80 : (score > 7'd40) ? 7'd90 : 7'd100;
			ST_RAND_LOSS:
				t = (loss > 16'd15) ? 7'd65 : (loss > 16'd8) ? 7'd75 :
				    (loss > 16'd3) ? 7'd85 : 7'd95;
			ST_DELAY_FLAT:
				t = (score > 7'd60) ? 7'd80 : 7'd90;
			ST_DELAY_RISE:
				t = (score >= 7'd90) ? 7'd40 : (score >= 7'd70) ? 7'd55 :
				    (score >= 7'd50) ? 7'd65 : 7'd80;
			ST_BURST_LOSS:
				t = (score >= 7'd95) ? 7'd30 : (score >= 7'd80) ? 7'd40 :
				    (score >= 7'd60) ? 7'd50 : 7'd60;
			ST_RECOVER:
				t = 7'd65;
			default:
				t = SCALE_FULL;
		endcase
		if (loss != '0 && score > CAP_SCORE && t > CAP_SCALE) begin
			t = CAP_SCALE;
		end
		return t;
	endfunction

endpackage

// ===== hdl/aws_scale_ctrl.sv =====
// Suppression decision, target pick and step-limited scale update for one ACK.
module aws_scale_ctrl (
	input  logic [aws_pkg::STATE_W-1:0] conn_state,
	input  logic [aws_pkg::SCORE_W-1:0] cong_level,
	input  logic [aws_pkg::LOSS_W-1:0]  loss_count,
	input  logic [aws_pkg::SCALE_W-1:0] scale_in,
	input  logic [aws_pkg::CNT_W-1:0]   cur_cnt,
	input  logic [aws_pkg::STEP_W-1:0]  up_step,
	input  logic [aws_pkg::STEP_W-1:0]  down_step,
	output aws_pkg::decision_t          dec
);
	import aws_pkg::*;

	logic               supp;
	logic [SCALE_W-1:0] target;
	logic [SCALE_W-1:0] base;
	logic [SCALE_W-1:0] diff;
	logic [SCALE_W-1:0] moved;

	// drop the ACK in heavy burst loss, at most two in a row
	assign supp   = (conn_state == ST_BURST_LOSS) && (cur_cnt < SUPP_MAX) &&
	                (cong_level >= SUPP_SCORE);
	assign target = pick_target(conn_state, cong_level, loss_count);
	assign base   = (scale_in == '0) ? SCALE_FULL : scale_in;

	// advance toward the target, clamped by the step registers
	always_comb begin
		diff  = '0;
		moved = base;
		if (target > base) begin
			diff  = target - base;
			moved = base + ((diff > up_step) ? up_step : diff);
		end else if (target < base) begin
			diff  = base - target;
			moved = base - ((diff > down_step) ? down_step : diff);
		end
	end

	// pack the decision
	always_comb begin
		dec.suppress = supp;
		dec.scale    = supp ? scale_in : moved;
		if (supp) begin
			dec.cnt = cur_cnt + CNT_W'(1);
		end else if (conn_state == ST_NORMAL) begin
			dec.cnt = '0;
		end else begin
			dec.cnt = cur_cnt;
		end
		dec.dup = (!supp && conn_state == ST_RAND_LOSS) ? DUP_LOSSY : DUP_BASE;
	end

endmodule

// ===== hdl/ack_window_shaper.sv =====
// Top level of the ACK window shaper: config registers, state and the result pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | sink      | in_valid/in_stall  | conn_state cong_level loss_count window_in
//  out     | source    | out_valid/out_stall| verdict window_out dup_threshold scale_out
//  cfg     | sink      | cfg_valid/cfg_ready| cfg_index cfg_data
//
// One ACK is taken every cycle unless in_stall is high; its result goes through all the
// stages in order to the out port. The five stages are: input register, scale register,
// window-times-scale product, reciprocal divide by 100, clamp and output register.
// Reset loads the register defaults, a scale of 100, a suppress count of zero and
// empties the pipeline. A stalled output keeps taking ACKs until every stage holds one.
module ack_window_shaper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [aws_pkg::STATE_W-1:0]   conn_state,
	input  logic [aws_pkg::SCORE_W-1:0]   cong_level,
	input  logic [aws_pkg::LOSS_W-1:0]    loss_count,
	input  logic [aws_pkg::WIN_W-1:0]     window_in,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [aws_pkg::VERDICT_W-1:0] verdict,
	output logic [aws_pkg::WIN_W-1:0]     window_out,
	output logic [aws_pkg::DUP_W-1:0]     dup_threshold,
	output logic [aws_pkg::SCALE_W-1:0]   scale_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [aws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aws_pkg::CFG_DAT_W-1:0] cfg_data
);
	import aws_pkg::*;

	// config and state
	logic [WIN_W-1:0]   min_window_q;
	logic [STEP_W-1:0]  up_step_q;
	logic [STEP_W-1:0]  down_step_q;
	logic [SCALE_W-1:0] scale_q;
	logic [CNT_W-1:0]   supp_cnt_q;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	// stage 1: captured ACK
	logic [STATE_W-1:0] st_s1;
	logic [SCORE_W-1:0] score_s1;
	logic [LOSS_W-1:0]  loss_s1;
	logic [WIN_W-1:0]   win_s1;

	// stage 2..4 payload
	logic               supp_s2, supp_s3, supp_s4;
	logic [SCALE_W-1:0] scale_s2, scale_s3, scale_s4;
	logic [DUP_W-1:0]   dup_s2, dup_s3, dup_s4;
	logic [WIN_W-1:0]   win_s2, win_s3, win_s4;
	logic [PROD_W-1:0]  prod_s3;
	logic [WIN_W-1:0]   quo_s4;

	// stage 5: output register
	logic [VERDICT_W-1:0] verdict_s5;
	logic [WIN_W-1:0]     win_out_s5;
	logic [DUP_W-1:0]     dup_s5;
	logic [SCALE_W-1:0]   scale_s5;

	decision_t          dec;
	logic [FULL_W-1:0]  recip_full;
	logic [WIN_W-1:0]   clamped;

	// stage can load when empty or when its content moves on
	assign rdy5     = !v_s5 || !out_stall;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	assign cfg_ready = 1'b1;

	// config register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_window_q <= MIN_WINDOW_RST;
			up_step_q    <= UP_STEP_RST;
			down_step_q  <= DOWN_STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_WINDOW: min_window_q <= cfg_data;
				REG_UP_STEP:    up_step_q    <= cfg_data[STEP_W-1:0];
				REG_DOWN_STEP:  down_step_q  <= cfg_data[STEP_W-1:0];
				default:        ;
			endcase
		end
	end

	aws_scale_ctrl u_ctrl (
		.conn_state (st_s1),
		.cong_level (score_s1),
		.loss_count (loss_s1),
		.scale_in   (scale_q),
		.cur_cnt    (supp_cnt_q),
		.up_step    (up_step_q),
		.down_step  (down_step_q),
		.dec        (dec)
	);

	// commit the scale and suppress count as the ACK leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= SCALE_FULL;
			supp_cnt_q <= '0;
		end else if (v_s1 && rdy2) begin
			scale_q    <= dec.scale;
			supp_cnt_q <= dec.cnt;
		end
	end

	// advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	assign recip_full = FULL_W'(prod_s3) * FULL_W'(DIV_MULT);
	assign clamped    = (quo_s4 < min_window_q) ? min_window_q : quo_s4;

	// advance stage payloads
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			st_s1    <= conn_state;
			score_s1 <= cong_level;
			loss_s1  <= loss_count;
			win_s1   <= window_in;
		end
		if (rdy2 && v_s1) begin
			supp_s2  <= dec.suppress;
			scale_s2 <= dec.scale;
			dup_s2   <= dec.dup;
			win_s2   <= win_s1;
		end
		if (rdy3 && v_s2) begin
			supp_s3  <= supp_s2;
			scale_s3 <= scale_s2;
			dup_s3   <= dup_s2;
			win_s3   <= win_s2;
			prod_s3  <= PROD_W'(win_s2) * PROD_W'(scale_s2);
		end
		if (rdy4 && v_s3) begin
			supp_s4  <= supp_s3;
			scale_s4 <= scale_s3;
			dup_s4   <= dup_s3;
			win_s4   <= win_s3;
			quo_s4   <= recip_full[DIV_SHIFT +: WIN_W];
		end
		if (rdy5 && v_s4) begin
			scale_s5 <= scale_s4;
			dup_s5   <= dup_s4;
			if (supp_s4) begin
				verdict_s5 <= VERDICT_SUPP;
				win_out_s5 <= win_s4;
			end else begin
				verdict_s5 <= (clamped != win_s4) ? VERDICT_MOD : VERDICT_SAME;
				win_out_s5 <= clamped;
			end
		end
	end

	assign out_valid     = v_s5;
	assign verdict       = verdict_s5;
	assign window_out    = win_out_s5;
	assign dup_threshold = dup_s5;
	assign scale_out     = scale_s5;

	// suppression never runs past two in a row
	a_supp_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		supp_cnt_q <= SUPP_MAX)
		else $error("suppress count above limit");

	// smoothed scale stays a valid percentage
	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		scale_q <= SCALE_FULL)
		else $error("smoothed scale above 100");

	// input stalls only when stage 1 is occupied and blocked
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5))
		else $error("input stalled with an empty stage");

	// scaling by at most 100 percent never grows the window
	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (quo_s4 <= win_s4))
		else $error("divide result exceeds input window");

endmodule

// ===== tb/tb_ack_window_shaper.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the ACK window shaper: queued stimulus, driver, monitor and predictor.
module tb_ack_window_shaper;
	import aws_pkg::*;

	// state codes with no package name, spare register index
	localparam logic [STATE_W-1:0]   ST_OTHER  = 3'd6;
	localparam logic [STATE_W-1:0]   ST_UNUSED = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int                   IDLE_LIMIT = 5000;

	typedef struct packed {
		logic [STATE_W-1:0] state;
		logic [SCORE_W-1:0] score;
		logic [LOSS_W-1:0]  loss;
		logic [WIN_W-1:0]   win;
	} ack_t;

	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [WIN_W-1:0]     window;
		logic [DUP_W-1:0]     dup;
		logic [SCALE_W-1:0]   scale;
	} shaped_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [STATE_W-1:0]   conn_state = '0;
	logic [SCORE_W-1:0]   cong_level = '0;
	logic [LOSS_W-1:0]    loss_count = '0;
	logic [WIN_W-1:0]     window_in = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [VERDICT_W-1:0] verdict;
	logic [WIN_W-1:0]     window_out;
	logic [DUP_W-1:0]     dup_threshold;
	logic [SCALE_W-1:0]   scale_out;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	// predictor copy of registers and state
	logic [WIN_W-1:0]   cfg_min_window = MIN_WINDOW_RST;
	logic [STEP_W-1:0]  cfg_up_step    = UP_STEP_RST;
	logic [STEP_W-1:0]  cfg_down_step  = DOWN_STEP_RST;
	logic [SCALE_W-1:0] kept_scale     = SCALE_FULL;
	logic [CNT_W-1:0]   supp_count     = '0;

	ack_t    ack_backlog[$];
	shaped_t shaped_q[$];
	int      mismatch_count = 0;

	// sender and receiver pacing
	int      burst_left = 1;
	int      gap_left = 0;
	int      burst_no = 0;
	logic    drain_hold = 1'b0;
	int      stall_left = 0;
	int      stall_kind = 0;
	int      idle_cycles = 0;

	ack_window_shaper dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.conn_state    (conn_state),
		.cong_level    (cong_level),
		.loss_count    (loss_count),
		.window_in     (window_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.verdict       (verdict),
		.window_out    (window_out),
		.dup_threshold (dup_threshold),
		.scale_out     (scale_out),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// target scale per connection state, capped on loss with a high score
	function automatic logic [SCALE_W-1:0] ack_target(input ack_t a);
		logic [SCALE_W-1:0] t;
		case (a.state)
			ST_NORMAL:
				t = (a.loss > 5) ? 7'd80 : (a.score > 40) ? 7'd90 : 7'd100;
			ST_RAND_LOSS:
				t = (a.loss > 15) ? 7'd65 : (a.loss > 8) ? 7'd75 :
				    (a.loss > 3) ? 7'd85 : 7'd95;
			ST_DELAY_FLAT:
				t = (a.score > 60) ? 7'd80 : 7'd90;
			ST_DELAY_RISE:
				t = (a.score >= 90) ? 7'd40 : (a.score >= 70) ? 7'd55 :
				    (a.score >= 50) ? 7'd65 : 7'd80;
			ST_BURST_LOSS:
				t = (a.score >= 95) ? 7'd30 : (a.score >= 80) ? 7'd40 :
				    (a.score >= 60) ? 7'd50 : 7'd60;
			ST_RECOVER:
				t = 7'd65;
			default:
				t = SCALE_FULL;
		endcase
		if (a.loss != 0 && a.score > CAP_SCORE && t > CAP_SCALE) begin
			t = CAP_SCALE;
		end
		return t;
	endfunction

	// shape one ACK and advance the kept scale and suppress count
	function automatic shaped_t shape_ack(input ack_t a);
		shaped_t            r;
		logic [SCALE_W-1:0] cur;
		logic [SCALE_W-1:0] tgt;
		logic [SCALE_W-1:0] d;
		logic [PROD_W-1:0]  prod;
		logic [WIN_W-1:0]   nw;
		if (a.state == ST_BURST_LOSS && supp_count < SUPP_MAX && a.score >= SUPP_SCORE) begin
			supp_count = supp_count + 1'b1;
			r.verdict  = VERDICT_SUPP;
			r.window   = a.win;
			r.dup      = DUP_BASE;
			r.scale    = kept_scale;
			return r;
		end
		tgt = ack_target(a);
		cur = (kept_scale == 0) ? SCALE_FULL : kept_scale;
		if (tgt > cur) begin
			d = tgt - cur;
			if (d > cfg_up_step) begin
				d = cfg_up_step;
			end
			cur = cur + d;
		end else if (tgt < cur) begin
			d = cur - tgt;
			if (d > cfg_down_step) begin
				d = cfg_down_step;
			end
			cur = cur - d;
		end
		prod = a.win * cur;
		nw = WIN_W'(prod / 100);
		if (nw < cfg_min_window) begin
			nw = cfg_min_window;
		end
		kept_scale = cur;
		if (a.state == ST_NORMAL) begin
			supp_count = '0;
		end
		r.verdict = (nw != a.win) ? VERDICT_MOD : VERDICT_SAME;
		r.window  = nw;
		r.dup     = (a.state == ST_RAND_LOSS) ? DUP_LOSSY : DUP_BASE;
		r.scale   = cur;
		return r;
	endfunction

	// random ACK: thresholds are reached by the full score range, losses small or large
	function automatic ack_t rand_ack();
		ack_t a;
		a.state = STATE_W'($urandom_range(7));
		a.score = ($urandom_range(1) == 0) ? SCORE_W'($urandom_range(127)) :
		          SCORE_W'($urandom_range(38, 101));
		a.loss  = ($urandom_range(3) == 0) ? LOSS_W'($urandom) : LOSS_W'($urandom_range(20));
		case ($urandom_range(9))
			0:       a.win = '0;
			1:       a.win = '1;
			2:       a.win = WIN_W'($urandom_range(8192));
			default: a.win = WIN_W'($urandom);
		endcase
		return a;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// write one register, then mirror it in the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MIN_WINDOW: cfg_min_window = data;
			REG_UP_STEP:    cfg_up_step = data[STEP_W-1:0];
			REG_DOWN_STEP:  cfg_down_step = data[STEP_W-1:0];
			default:        ;
		endcase
	endtask

	// settle at a falling edge once every ACK has gone in and every result come out
	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (ack_backlog.size() != 0 || in_valid || shaped_q.size() != 0);
	endtask

	// driver: bursts from the pending queue, gaps between them, now and then a full drain
	always @(posedge clk) begin : driver_proc
		ack_t item_next;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				shaped_q.push_back(shape_ack('{conn_state, cong_level, loss_count,
					window_in}));
			end
			if (in_valid && in_stall) begin
				// hold the stalled beat
			end else if (drain_hold) begin
				in_valid <= 1'b0;
				if (shaped_q.size() == 0) begin
					drain_hold <= 1'b0;
				end
			end else if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (ack_backlog.size() != 0) begin
				item_next = ack_backlog.pop_front();
				in_valid   <= 1'b1;
				conn_state <= item_next.state;
				cong_level <= item_next.score;
				loss_count <= item_next.loss;
				window_in  <= item_next.win;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 12);
					drain_hold <= (burst_no == 2) || ($urandom_range(5) == 0);
					burst_no   <= burst_no + 1;
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check each result beat against the oldest prediction, and pace the stall
	always @(posedge clk) begin : monitor_proc
		shaped_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (shaped_q.size() == 0) begin
				report_mismatch("result beat with nothing expected", window_out, 0);
			end else begin
				want = shaped_q.pop_front();
				if (verdict !== want.verdict) begin
					report_mismatch("verdict", verdict, want.verdict);
				end
				if (window_out !== want.window) begin
					report_mismatch("window_out", window_out, want.window);
				end
				if (dup_threshold !== want.dup) begin
					report_mismatch("dup_threshold", dup_threshold, want.dup);
				end
				if (scale_out !== want.scale) begin
					report_mismatch("scale_out", scale_out, want.scale);
				end
			end
		end
		// stall pattern: free-running, sparse random, or solid stretches
		if (stall_left == 0) begin
			stall_kind <= $urandom_range(2);
			stall_left <= $urandom_range(1, 50);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_kind)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(3) == 0);
			default: out_stall <= 1'b1;
		endcase
	end

	// watchdog: end the run when no beat moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_ack_window_shaper NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic [WIN_W-1:0]  mw;
		logic [STEP_W-1:0] us;
		logic [STEP_W-1:0] ds;
		logic [CFG_DAT_W-1:0] junk;
		int n;
		int run_len;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed ACKs at the reset register values
		ack_backlog.push_back('{ST_NORMAL, 7'd0, 16'd0, 16'd0});
		ack_backlog.push_back('{ST_NORMAL, 7'd41, 16'd0, 16'hFFFF});
		ack_backlog.push_back('{ST_NORMAL, 7'd40, 16'd6, 16'd10000});
		ack_backlog.push_back('{ST_RAND_LOSS, 7'd0, 16'd16, 16'd50000});
		ack_backlog.push_back('{ST_RAND_LOSS, 7'd0, 16'd9, 16'd30000});
		ack_backlog.push_back('{ST_RAND_LOSS, 7'd0, 16'd4, 16'd20000});
		ack_backlog.push_back('{ST_RAND_LOSS, 7'd0, 16'd3, 16'd20000});
		ack_backlog.push_back('{ST_DELAY_FLAT, 7'd61, 16'd0, 16'd40000});
		ack_backlog.push_back('{ST_DELAY_FLAT, 7'd60, 16'd0, 16'd40000});
		ack_backlog.push_back('{ST_DELAY_RISE, 7'd90, 16'd0, 16'd60000});
		ack_backlog.push_back('{ST_DELAY_RISE, 7'd70, 16'd0, 16'd60000});
		ack_backlog.push_back('{ST_DELAY_RISE, 7'd50, 16'd0, 16'd60000});
		ack_backlog.push_back('{ST_BURST_LOSS, 7'd95, 16'd0, 16'd60000});
		ack_backlog.push_back('{ST_BURST_LOSS, 7'd80, 16'd0, 16'd60000});
		ack_backlog.push_back('{ST_BURST_LOSS, 7'd60, 16'd0, 16'd60000});
		ack_backlog.push_back('{ST_RECOVER, 7'd0, 16'd0, 16'd60000});
		ack_backlog.push_back('{ST_OTHER, 7'd0, 16'd0, 16'd60000});
		ack_backlog.push_back('{ST_UNUSED, 7'd127, 16'd0, 16'd60000});
		// loss cap, and a score above 100
		ack_backlog.push_back('{ST_NORMAL, 7'd71, 16'd1, 16'd60000});
		ack_backlog.push_back('{ST_DELAY_RISE, 7'd127, 16'hFFFF, 16'hFFFF});
		// two suppressed ACKs, then the count blocks a third until a normal ACK clears it
		ack_backlog.push_back('{ST_BURST_LOSS, 7'd99, 16'd7, 16'd12345});
		ack_backlog.push_back('{ST_BURST_LOSS, 7'd99, 16'd7, 16'd12345});
		ack_backlog.push_back('{ST_BURST_LOSS, 7'd127, 16'd7, 16'd12345});
		ack_backlog.push_back('{ST_NORMAL, 7'd0, 16'd0, 16'hFFFF});
		ack_backlog.push_back('{ST_BURST_LOSS, 7'd100, 16'd0, 16'd0});

		// random phases, each under its own register setting
		for (int phase = 1; phase <= 6; phase++) begin
			wait_idle();
			case (phase)
				1: begin
					mw = '0;
					us = 7'd1;
					ds = 7'd1;
				end
				2: begin
					mw = '1;
					us = 7'd100;
					ds = 7'd100;
				end
				3: begin
					mw = '0;
					us = 7'd0;
					ds = 7'd0;
				end
				4: begin
					mw = WIN_W'($urandom_range(8192));
					us = 7'd127;
					ds = 7'd127;
				end
				default: begin
					mw = ($urandom_range(1) == 0) ? WIN_W'($urandom_range(8192)) :
					     WIN_W'($urandom);
					us = STEP_W'($urandom_range(127));
					ds = STEP_W'($urandom_range(127));
				end
			endcase
			write_reg(REG_MIN_WINDOW, mw);
			// upper data bits beyond the step width are don't-care
			junk = CFG_DAT_W'($urandom);
			write_reg(REG_UP_STEP, {junk[CFG_DAT_W-1:STEP_W], us});
			junk = CFG_DAT_W'($urandom);
			write_reg(REG_DOWN_STEP, {junk[CFG_DAT_W-1:STEP_W], ds});
			if (phase == 3) begin
				write_reg(REG_SPARE, CFG_DAT_W'($urandom));
			end
			@(negedge clk);
			n = 0;
			while (n < 100) begin
				if ($urandom_range(9) == 0) begin
					// run of suppression candidates, sometimes closed by a normal ACK
					run_len = $urandom_range(2, 4);
					repeat (run_len) begin
						ack_backlog.push_back('{ST_BURST_LOSS, SCORE_W'($urandom_range(99, 127)),
							LOSS_W'($urandom), WIN_W'($urandom)});
					end
					n += run_len;
					if ($urandom_range(1) == 0) begin
						ack_backlog.push_back('{ST_NORMAL, SCORE_W'($urandom_range(127)),
							LOSS_W'($urandom_range(8)), WIN_W'($urandom)});
						n++;
					end
				end else begin
					ack_backlog.push_back(rand_ack());
					n++;
				end
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("tb_ack_window_shaper OK");
		end else begin
			$display("tb_ack_window_shaper NOT OK");
		end
		$finish;
	end

endmodule
